FILE: hdl/sobb_pkg.sv
// ----------------------------------------------------------------------------
// sobb_pkg
// shared constants, types and rounding helper for the sphere/box push block
// ----------------------------------------------------------------------------
`default_nettype none

package sobb_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int QROT       = 14;
  localparam int AX_W       = 22;
  localparam int SQ_STAGES  = 32;
  localparam int DIV_STAGES = 31;

  localparam logic [30:0] RADIUS_RST = 31'(100 << FRAC_BITS);

  typedef logic signed [31:0]     pos_t;
  typedef logic signed [AX_W-1:0] axis_t;

  // add half, floor shift by the quaternion fraction width
  function automatic logic signed [41:0] rnd14(input logic signed [55:0] v);
    logic signed [55:0] t;
    t = v + 56'sd8192;
    return t[55:QROT];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/sobb_if.sv
// ----------------------------------------------------------------------------
// sobb channel interfaces
// request, result and radius write channels with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface sobb_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] offset_x;
  logic signed [31:0] offset_y;
  logic signed [31:0] offset_z;
  logic [30:0]        half_extent_x;
  logic [30:0]        half_extent_y;
  logic [30:0]        half_extent_z;
  logic signed [15:0] rot_w;
  logic signed [15:0] rot_x;
  logic signed [15:0] rot_y;
  logic signed [15:0] rot_z;
  modport source (output valid, offset_x, offset_y, offset_z, half_extent_x, half_extent_y,
                  half_extent_z, rot_w, rot_x, rot_y, rot_z, input ready);
  modport sink (input valid, offset_x, offset_y, offset_z, half_extent_x, half_extent_y,
                half_extent_z, rot_w, rot_x, rot_y, rot_z, output ready);
endinterface

interface sobb_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] push_x;
  logic signed [31:0] push_y;
  logic signed [31:0] push_z;
  logic               hit;
  modport source (output valid, push_x, push_y, push_z, hit, input ready);
  modport sink (input valid, push_x, push_y, push_z, hit, output ready);
endinterface

interface sobb_cfg_if;
  logic        valid;
  logic        ready;
  logic [30:0] sphere_radius;
  modport source (output valid, sphere_radius, input ready);
  modport sink (input valid, sphere_radius, output ready);
endinterface

`default_nettype wire

FILE: hdl/sobb_isqrt.sv
// ----------------------------------------------------------------------------
// sobb_isqrt
// pipelined digit-by-digit integer square root, one result bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module sobb_isqrt import sobb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] rad_in,
  output logic [31:0]      root
);

  logic [63:0] n_r   [SQ_STAGES];
  logic [63:0] res_r [SQ_STAGES];
  logic [63:0] n_nxt [SQ_STAGES];
  logic [63:0] res_nxt [SQ_STAGES];

  always_comb begin
    logic [63:0] n_in;
    logic [63:0] res_in;
    logic [63:0] bt;
    for (int k = 0; k < SQ_STAGES; k++) begin
      n_in   = (k == 0) ? rad_in : n_r[k-1];
      res_in = (k == 0) ? 64'd0 : res_r[k-1];
      bt     = 64'd1 << (62 - 2 * k);
      if (n_in >= res_in + bt) begin
        n_nxt[k]   = n_in - (res_in + bt);
        res_nxt[k] = (res_in >> 1) + bt;
      end else begin
        n_nxt[k]   = n_in;
        res_nxt[k] = res_in >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQ_STAGES; k++) begin
        n_r[k]   <= n_nxt[k];
        res_r[k] <= res_nxt[k];
      end
    end
  end

  assign root = res_r[SQ_STAGES-1][31:0];

endmodule

`default_nettype wire

FILE: hdl/sobb_div.sv
// ----------------------------------------------------------------------------
// sobb_div
// pipelined restoring divider, 31-bit quotient, one bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module sobb_div import sobb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] num,
  input  wire logic [31:0] den,
  output logic [DIV_STAGES-1:0] quo
);

  logic [31:0]           rem_r [DIV_STAGES];
  logic [30:0]           low_r [DIV_STAGES];
  logic [DIV_STAGES-1:0] q_r   [DIV_STAGES];
  logic [31:0]           den_r [DIV_STAGES];
  logic [31:0]           rem_nxt [DIV_STAGES];
  logic [DIV_STAGES-1:0] q_nxt   [DIV_STAGES];

  // quotient is known to fit, so the top part starts below the divisor
  always_comb begin
    logic [31:0]           rem_in;
    logic [30:0]           low_in;
    logic [DIV_STAGES-1:0] q_in;
    logic [31:0]           d_in;
    logic [32:0]           t;
    logic                  ge;
    for (int j = 0; j < DIV_STAGES; j++) begin
      rem_in = (j == 0) ? num[62:31] : rem_r[j-1];
      low_in = (j == 0) ? num[30:0] : low_r[j-1];
      q_in   = (j == 0) ? '0 : q_r[j-1];
      d_in   = (j == 0) ? den : den_r[j-1];
      t      = {rem_in, low_in[30-j]};
      ge     = (t >= {1'b0, d_in});
      rem_nxt[j] = ge ? 32'(t - {1'b0, d_in}) : t[31:0];
      q_nxt[j]   = {q_in[DIV_STAGES-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < DIV_STAGES; j++) begin
        rem_r[j] <= rem_nxt[j];
        q_r[j]   <= q_nxt[j];
        low_r[j] <= (j == 0) ? num[30:0] : low_r[j-1];
        den_r[j] <= (j == 0) ? den : den_r[j-1];
      end
    end
  end

  assign quo = q_r[DIV_STAGES-1];

endmodule

`default_nettype wire

FILE: hdl/sphere_obb_penetration_push.sv
// ----------------------------------------------------------------------------
// sphere_obb_penetration_push
// sphere against oriented box: closest point, distance and push-out vector
// ----------------------------------------------------------------------------
//  channel  direction  contents
//  in_ch    sink       offset, half extents, rotation quaternion per request
//  out_ch   source     push vector and hit flag, one per request
//  cfg_ch   sink       sphere radius write, always ready
//
//  fully pipelined: one request per cycle through 73 register stages while the output is not stalled
//  most of the stages sit in the 32-stage square root and the 31-stage divider
//  rst_n is synchronous, clears valid bits and restores radius 100.0
//  a stalled result holds the whole pipeline; nothing is dropped or repeated
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_obb_penetration_push import sobb_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  sobb_cfg_if.sink    cfg_ch,
  sobb_in_if.sink     in_ch,
  sobb_out_if.source  out_ch
);

  localparam int NV = 8 + SQ_STAGES + 1 + DIV_STAGES;

  logic        en;
  logic        out_valid_r;
  logic [NV-1:0] vld_r;
  logic [30:0] rad_r;

  // whole pipe moves unless a result sits unclaimed at the output
  assign en           = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = en;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rad_r <= RADIUS_RST;
    end else if (cfg_ch.valid) begin
      rad_r <= cfg_ch.sphere_radius;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[NV-2:0], in_ch.valid};
      out_valid_r <= vld_r[NV-1];
    end
  end

  // stage 0: request capture
  pos_t               off0_r [3];
  logic [30:0]        ext0_r [3];
  logic signed [15:0] qw_r, qx_r, qy_r, qz_r;

  // stage 1: box axes, rows of the rotation matrix
  axis_t       ax1_r [3][3];
  pos_t        off1_r [3];
  logic [30:0] ext1_r [3];
  axis_t       ax1_nxt [3][3];

  // stage 2: offset times axis products
  logic signed [53:0] pa2_r [3][3];
  axis_t              ax2_r [3][3];
  pos_t               off2_r [3];
  logic [30:0]        ext2_r [3];

  // stage 3: clamped projections
  pos_t  proj3_r [3];
  axis_t ax3_r [3][3];
  pos_t  off3_r [3];
  pos_t  proj3_nxt [3];

  // stage 4: projection times axis
  logic signed [53:0] pc4_r [3][3];
  pos_t               off4_r [3];

  // stage 5: direction from closest point to center, saturated
  pos_t        dir5_r [3];
  pos_t        dir5_nxt [3];
  logic [31:0] mag5_nxt [3];

  // stage 6 and 7: squares, then their sum
  logic [63:0] sq6_r [3];
  logic [31:0] mag6_r [3];
  logic [2:0]  sgn6_r;
  logic [63:0] sum7_r;
  logic [31:0] mag7_r [3];
  logic [2:0]  sgn7_r;

  // carried alongside the square root
  logic [31:0] magq_r [SQ_STAGES][3];
  logic [2:0]  sgnq_r [SQ_STAGES];
  logic [31:0] dist_w;

  // hit stage
  logic [62:0] prod_r [3];
  logic [31:0] dist_r;
  logic        hit_r;
  logic        nz_r;
  logic [2:0]  sgnh_r;

  // carried alongside the divider
  logic       hitd_r [DIV_STAGES];
  logic       nzd_r  [DIV_STAGES];
  logic [2:0] sgnd_r [DIV_STAGES];
  logic [DIV_STAGES-1:0] quo [3];

  logic signed [31:0] push_r [3];
  logic               hit_out_r;

  // quaternion to axes, Q2.28 exact then rounded to Q1.14
  always_comb begin
    logic signed [31:0] pxx, pyy, pzz, pxy, pxz, pyz, pxw, pyw, pzw;
    logic signed [35:0] raw [3][3];
    localparam logic signed [35:0] ONE = 36'sd268435456;
    pxx = qx_r * qx_r;  pyy = qy_r * qy_r;  pzz = qz_r * qz_r;
    pxy = qx_r * qy_r;  pxz = qx_r * qz_r;  pyz = qy_r * qz_r;
    pxw = qx_r * qw_r;  pyw = qy_r * qw_r;  pzw = qz_r * qw_r;
    raw[0][0] = ONE - 36'sd2 * (36'(pyy) + 36'(pzz));
    raw[0][1] = 36'sd2 * (36'(pxy) + 36'(pzw));
    raw[0][2] = 36'sd2 * (36'(pxz) - 36'(pyw));
    raw[1][0] = 36'sd2 * (36'(pxy) - 36'(pzw));
    raw[1][1] = ONE - 36'sd2 * (36'(pxx) + 36'(pzz));
    raw[1][2] = 36'sd2 * (36'(pyz) + 36'(pxw));
    raw[2][0] = 36'sd2 * (36'(pxz) + 36'(pyw));
    raw[2][1] = 36'sd2 * (36'(pyz) - 36'(pxw));
    raw[2][2] = ONE - 36'sd2 * (36'(pxx) + 36'(pyy));
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        ax1_nxt[i][k] = AX_W'(rnd14(56'(raw[i][k])));
      end
    end
  end

  // projection on each axis, clamped to the half extent
  always_comb begin
    logic signed [55:0] s;
    logic signed [41:0] r;
    logic signed [41:0] e;
    for (int i = 0; i < 3; i++) begin
      s = 56'(pa2_r[i][0]) + 56'(pa2_r[i][1]) + 56'(pa2_r[i][2]);
      r = rnd14(s);
      e = $signed({11'b0, ext2_r[i]});
      if (r > e) begin
        proj3_nxt[i] = e[31:0];
      end else if (r < -e) begin
        proj3_nxt[i] = 32'(-e);
      end else begin
        proj3_nxt[i] = r[31:0];
      end
    end
  end

  // closest point and direction
  always_comb begin
    logic signed [55:0] s;
    logic signed [41:0] r;
    logic signed [42:0] d;
    for (int k = 0; k < 3; k++) begin
      s = 56'(pc4_r[0][k]) + 56'(pc4_r[1][k]) + 56'(pc4_r[2][k]);
      r = rnd14(s);
      d = 43'(off4_r[k]) - 43'(r);
      if (d > 43'sd2147483647) begin
        dir5_nxt[k] = 32'sh7fffffff;
      end else if (d < -43'sd2147483648) begin
        dir5_nxt[k] = 32'sh80000000;
      end else begin
        dir5_nxt[k] = d[31:0];
      end
    end
  end

  // magnitude of the most negative value still fits unsigned
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag5_nxt[k] = dir5_r[k][31] ? 32'(-dir5_r[k]) : 32'(dir5_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      off0_r[0] <= in_ch.offset_x;
      off0_r[1] <= in_ch.offset_y;
      off0_r[2] <= in_ch.offset_z;
      ext0_r[0] <= in_ch.half_extent_x;
      ext0_r[1] <= in_ch.half_extent_y;
      ext0_r[2] <= in_ch.half_extent_z;
      qw_r <= in_ch.rot_w;
      qx_r <= in_ch.rot_x;
      qy_r <= in_ch.rot_y;
      qz_r <= in_ch.rot_z;

      for (int i = 0; i < 3; i++) begin
        off1_r[i]  <= off0_r[i];
        ext1_r[i]  <= ext0_r[i];
        off2_r[i]  <= off1_r[i];
        ext2_r[i]  <= ext1_r[i];
        off3_r[i]  <= off2_r[i];
        proj3_r[i] <= proj3_nxt[i];
        off4_r[i]  <= off3_r[i];
        dir5_r[i]  <= dir5_nxt[i];
        for (int k = 0; k < 3; k++) begin
          ax1_r[i][k] <= ax1_nxt[i][k];
          ax2_r[i][k] <= ax1_r[i][k];
          pa2_r[i][k] <= off1_r[k] * ax1_r[i][k];
          ax3_r[i][k] <= ax2_r[i][k];
          pc4_r[i][k] <= proj3_r[i] * ax3_r[i][k];
        end
      end

      for (int k = 0; k < 3; k++) begin
        mag6_r[k] <= mag5_nxt[k];
        sgn6_r[k] <= dir5_r[k][31];
        sq6_r[k]  <= 64'(mag5_nxt[k]) * 64'(mag5_nxt[k]);
        mag7_r[k] <= mag6_r[k];
      end
      sum7_r <= sq6_r[0] + sq6_r[1] + sq6_r[2];
      sgn7_r <= sgn6_r;

      for (int j = 0; j < SQ_STAGES; j++) begin
        sgnq_r[j] <= (j == 0) ? sgn7_r : sgnq_r[j-1];
        for (int k = 0; k < 3; k++) begin
          magq_r[j][k] <= (j == 0) ? mag7_r[k] : magq_r[j-1][k];
        end
      end

      // depth only matters on a hit, where the distance is below the radius
      hit_r  <= (dist_w < {1'b0, rad_r});
      nz_r   <= (dist_w != 32'd0);
      dist_r <= dist_w;
      sgnh_r <= sgnq_r[SQ_STAGES-1];
      for (int k = 0; k < 3; k++) begin
        prod_r[k] <= 63'(magq_r[SQ_STAGES-1][k]) * 63'(rad_r - dist_w[30:0]);
      end

      for (int j = 0; j < DIV_STAGES; j++) begin
        hitd_r[j] <= (j == 0) ? hit_r  : hitd_r[j-1];
        nzd_r[j]  <= (j == 0) ? nz_r   : nzd_r[j-1];
        sgnd_r[j] <= (j == 0) ? sgnh_r : sgnd_r[j-1];
      end

      // push is zero when no hit or when the center lies inside the box
      hit_out_r <= hitd_r[DIV_STAGES-1];
      for (int k = 0; k < 3; k++) begin
        if (hitd_r[DIV_STAGES-1] && nzd_r[DIV_STAGES-1]) begin
          push_r[k] <= sgnd_r[DIV_STAGES-1][k] ? -$signed({1'b0, quo[k]})
                                               : $signed({1'b0, quo[k]});
        end else begin
          push_r[k] <= '0;
        end
      end
    end
  end

  sobb_isqrt u_isqrt (
    .clk    (clk),
    .en     (en),
    .rad_in (sum7_r),
    .root   (dist_w)
  );

  // rounded quotient: add half the divisor before dividing
  for (genvar g = 0; g < 3; g++) begin : g_div
    sobb_div u_div (
      .clk (clk),
      .en  (en),
      .num (64'(prod_r[g]) + 64'(dist_r >> 1)),
      .den (dist_r),
      .quo (quo[g])
    );
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.push_x = push_r[0];
  assign out_ch.push_y = push_r[1];
  assign out_ch.push_z = push_r[2];
  assign out_ch.hit    = hit_out_r;

  a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !hit_out_r |-> push_r[0] == 0 && push_r[1] == 0 && push_r[2] == 0)
    else $error("push nonzero without hit");

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r && vld_r == '0)
    else $error("pipeline not empty after reset");

  a_hit_rad: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[8 + SQ_STAGES] && hit_r |-> dist_r < {1'b0, rad_r})
    else $error("hit with distance not below radius");

endmodule

`default_nettype wire
